### src/rau_pkg.sv
package rau_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned FracW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned CntW  = 6;
  localparam int unsigned DefWidth = 32;

  typedef enum logic [OpW-1:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_NEG  = 3'd5,
    OP_CMP  = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_MUL2 = 9'b000000100,
    S_MUL3 = 9'b000001000,
    S_COMB = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

endpackage

### src/rational_arithmetic_unit.sv
// rational arithmetic unit
// input channel: in_valid_i / in_ready_o with req_type_i and fractions a and b
// output channel: out_valid_o / out_ready_i with res_num_o, res_den_o, order_o
// and status_o, one result item for each input item, in order
// one item at a time: in_ready_o is high only while the sequencer is idle
// a request code of 7, a zero denominator or a division by zero goes straight
// to the final state; compare and a zero numerator stop after the combine step
// fraction results: 3 products on one 32x32 multiplier, one combine step,
// a binary gcd on 64-bit values (one subtract or shift a cycle), then two
// restoring divisions by the gcd on one shared divider
// the result sits in an output register; while the receiver stalls the
// finished item waits there and the sequencer holds in its final state
// reset clears the sequencer and the output valid; no clearing pass is needed
// WIDTH sets the range checked for overflow, capped at 32 bits
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OpW-1:0]          req_type_i,
  input  logic signed [FracW-1:0] a_num_i,
  input  logic signed [FracW-1:0] a_den_i,
  input  logic signed [FracW-1:0] b_num_i,
  input  logic signed [FracW-1:0] b_den_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [FracW-1:0] res_num_o,
  output logic [FracW-2:0]        res_den_o,
  output logic [1:0]              order_o,
  output logic [1:0]              status_o
);

  localparam int unsigned EffW = (WIDTH > FracW) ? FracW : WIDTH;
  localparam logic [ProdW-1:0] Lim = ProdW'(1) << (EffW - 1);

  state_e state_q, state_d;
  op_e    op_q;
  logic [FracW-1:0] am_q, ad_q, bm_q, bd_q;
  logic a_neg_q, b_neg_q, neg_q;
  logic [ProdW-1:0] t1_q, t2_q, n_q, d_q, gx_q, gy_q, dv_q, rm_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0] st_q, ord_q;
  logic fr_q;
  logic out_valid_q;
  logic signed [FracW-1:0] res_num_q;
  logic [FracW-2:0] res_den_q;
  logic [1:0] order_q, status_q;

  logic [FracW-1:0] mx, my;
  logic [ProdW-1:0] prod;
  logic [FracW-1:0] in_am, in_ad, in_bm, in_bd;
  logic in_err, uses_b, in_acc;
  logic bneg_e, same;
  logic [ProdW-1:0] comb_n;
  logic comb_neg;
  logic signed [ProdW:0] ls, rs;
  logic [ProdW:0] rem_sh;
  logic div_ge;
  logic [ProdW-1:0] rm_nx, dv_nx;
  logic ok, out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign in_am = a_num_i[FracW-1] ? FracW'(0) - a_num_i : a_num_i;
  assign in_ad = a_den_i[FracW-1] ? FracW'(0) - a_den_i : a_den_i;
  assign in_bm = b_num_i[FracW-1] ? FracW'(0) - b_num_i : b_num_i;
  assign in_bd = b_den_i[FracW-1] ? FracW'(0) - b_den_i : b_den_i;

  assign uses_b = (req_type_i == OP_ADD) || (req_type_i == OP_SUB) ||
                  (req_type_i == OP_MUL) || (req_type_i == OP_DIV) ||
                  (req_type_i == OP_CMP);
  assign in_err = (a_den_i == '0) || (uses_b && b_den_i == '0) ||
                  (req_type_i == OP_DIV && b_num_i == '0);

  // shared multiplier operand selection
  always_comb begin
    mx = am_q;
    my = bd_q;
    unique case (state_q)
      S_MUL1: begin
        mx = am_q;
        case (op_q)
          OP_MUL:          my = bm_q;
          OP_NORM, OP_NEG: my = FracW'(1);
          default:         my = bd_q;
        endcase
      end
      S_MUL2: begin
        mx = bm_q;
        my = ad_q;
      end
      S_MUL3: begin
        mx = ad_q;
        case (op_q)
          OP_DIV:          my = bm_q;
          OP_NORM, OP_NEG: my = FracW'(1);
          default:         my = bd_q;
        endcase
      end
      default: begin
        mx = am_q;
        my = bd_q;
      end
    endcase
  end

  assign prod = mx * my;

  // combine products into a signed magnitude numerator
  assign bneg_e = (op_q == OP_SUB) ? !b_neg_q : b_neg_q;
  assign same   = (a_neg_q == bneg_e);

  always_comb begin
    comb_n   = t1_q;
    comb_neg = a_neg_q;
    case (op_q)
      OP_ADD, OP_SUB: begin
        if (same) begin
          comb_n   = t1_q + t2_q;
          comb_neg = a_neg_q;
        end else if (t1_q >= t2_q) begin
          comb_n   = t1_q - t2_q;
          comb_neg = a_neg_q;
        end else begin
          comb_n   = t2_q - t1_q;
          comb_neg = bneg_e;
        end
      end
      OP_MUL, OP_DIV: comb_neg = a_neg_q ^ b_neg_q;
      OP_NEG:         comb_neg = !a_neg_q;
      default:        comb_neg = a_neg_q;
    endcase
  end

  assign ls = a_neg_q ? (ProdW+1)'(0) - {1'b0, t1_q} : {1'b0, t1_q};
  assign rs = b_neg_q ? (ProdW+1)'(0) - {1'b0, t2_q} : {1'b0, t2_q};

  // shared restoring divider step, divisor is the gcd
  assign rem_sh = {rm_q, dv_q[ProdW-1]};
  assign div_ge = (rem_sh >= {1'b0, gx_q});
  assign rm_nx  = div_ge ? ProdW'(rem_sh - {1'b0, gx_q}) : rem_sh[ProdW-1:0];
  assign dv_nx  = {dv_q[ProdW-2:0], div_ge};

  assign ok = (d_q >= ProdW'(1)) && (d_q <= Lim - ProdW'(1)) &&
              (neg_q ? (n_q <= Lim) : (n_q <= Lim - ProdW'(1)));
  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == OP_NONE || in_err) state_d = S_FIN;
          else                                 state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_COMB;
      S_COMB: begin
        if (op_q == OP_CMP || comb_n == '0) state_d = S_FIN;
        else                                state_d = S_GCD;
      end
      S_GCD:  if (gx_q == gy_q) state_d = S_DIVN;
      S_DIVN: if (cnt_q == '1) state_d = S_DIVD;
      S_DIVD: if (cnt_q == '1) state_d = S_FIN;
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_load) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q    <= op_e'(req_type_i);
          am_q    <= in_am;
          ad_q    <= in_ad;
          bm_q    <= in_bm;
          bd_q    <= in_bd;
          a_neg_q <= a_num_i[FracW-1] ^ a_den_i[FracW-1];
          b_neg_q <= b_num_i[FracW-1] ^ b_den_i[FracW-1];
          ord_q   <= ORD_LT;
          fr_q    <= 1'b0;
          st_q    <= (req_type_i != OP_NONE && in_err) ? ST_ZERO : ST_OK;
        end
      end
      S_MUL1: t1_q <= prod;
      S_MUL2: t2_q <= prod;
      S_MUL3: d_q  <= prod;
      S_COMB: begin
        if (op_q == OP_CMP) begin
          ord_q <= (ls < rs) ? ORD_LT : ((ls == rs) ? ORD_EQ : ORD_GT);
        end else if (comb_n == '0) begin
          n_q   <= '0;
          d_q   <= ProdW'(1);
          neg_q <= 1'b0;
          fr_q  <= 1'b1;
        end else begin
          n_q   <= comb_n;
          neg_q <= comb_neg;
          gx_q  <= comb_n;
          gy_q  <= d_q;
        end
      end
      S_GCD: begin
        if (gx_q == gy_q) begin
          dv_q  <= n_q;
          rm_q  <= '0;
          cnt_q <= '0;
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1;
          gy_q <= gy_q >> 1;
          n_q  <= n_q >> 1;
          d_q  <= d_q >> 1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (gx_q > gy_q) begin
          gx_q <= gx_q - gy_q;
        end else begin
          gy_q <= gy_q - gx_q;
        end
      end
      S_DIVN: begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == '1) begin
          n_q  <= dv_nx;
          dv_q <= d_q;
          rm_q <= '0;
        end else begin
          dv_q <= dv_nx;
          rm_q <= rm_nx;
        end
      end
      S_DIVD: begin
        cnt_q <= cnt_q + CntW'(1);
        dv_q  <= dv_nx;
        rm_q  <= rm_nx;
        if (cnt_q == '1) begin
          d_q  <= dv_nx;
          fr_q <= 1'b1;
        end
      end
      S_FIN: begin
        if (out_load) begin
          order_q <= ord_q;
          if (fr_q && ok) begin
            res_num_q <= neg_q ? FracW'(0) - n_q[FracW-1:0] : n_q[FracW-1:0];
            res_den_q <= d_q[FracW-2:0];
            status_q  <= ST_OK;
          end else begin
            res_num_q <= '0;
            res_den_q <= '0;
            status_q  <= fr_q ? ST_OVF : st_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign order_o     = order_q;
  assign status_o    = status_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVN |-> gx_q != '0)
    else $error("division by zero gcd");

  a_err_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> res_den_o == '0 && res_num_o == '0)
    else $error("error item carries a fraction");

endmodule

### tb/tb_rational_arithmetic_unit.sv
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         ord;
    logic [1:0]         st;
  } frac_res_t;

  localparam int unsigned WIDTH_EFF = (DefWidth > 32) ? 32 : DefWidth;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [OpW-1:0]          req_type_i;
  logic signed [FracW-1:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [FracW-1:0] res_num_o;
  logic [FracW-2:0]        res_den_o;
  logic [1:0]              order_o, status_o;

  frac_res_t expected_q[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned cycle_cnt;
  bit          failed;

  rational_arithmetic_unit dut (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t rational_result(input op_e op, input logic signed [31:0] an,
                                                input logic signed [31:0] ad,
                                                input logic signed [31:0] bn,
                                                input logic signed [31:0] bd);
    frac_res_t r;
    logic aneg, bneg, rneg, uses_b;
    logic [63:0] amag, admag, bmag, bdmag, t1, t2, rn, rd, g, lim;
    logic signed [63:0] ls, rs;
    r = '0;
    r.st = ST_OK;
    uses_b = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    if (op == OP_NONE) return r;
    if (ad == 0 || ((uses_b || op == OP_CMP) && bd == 0) || (op == OP_DIV && bn == 0)) begin
      r.st = ST_ZERO;
      return r;
    end
    aneg = an[31] ^ ad[31];
    bneg = bn[31] ^ bd[31];
    amag = an[31] ? -64'(an) : 64'(an);
    admag = ad[31] ? -64'(ad) : 64'(ad);
    bmag = bn[31] ? -64'(bn) : 64'(bn);
    bdmag = bd[31] ? -64'(bd) : 64'(bd);
    case (op)
      OP_ADD, OP_SUB: begin
        if (op == OP_SUB) bneg = !bneg;
        t1 = amag * bdmag;
        t2 = bmag * admag;
        if (aneg == bneg) begin
          rn = t1 + t2;
          rneg = aneg;
        end else if (t1 >= t2) begin
          rn = t1 - t2;
          rneg = aneg;
        end else begin
          rn = t2 - t1;
          rneg = bneg;
        end
        rd = admag * bdmag;
      end
      OP_MUL: begin
        rn = amag * bmag;
        rd = admag * bdmag;
        rneg = aneg ^ bneg;
      end
      OP_DIV: begin
        rn = amag * bdmag;
        rd = admag * bmag;
        rneg = aneg ^ bneg;
      end
      OP_NEG: begin
        rn = amag;
        rd = admag;
        rneg = !aneg;
      end
      OP_CMP: begin
        ls = amag * bdmag;
        rs = bmag * admag;
        if (aneg) ls = -ls;
        if (bneg) rs = -rs;
        r.ord = (ls < rs) ? ORD_LT : ((ls == rs) ? ORD_EQ : ORD_GT);
        return r;
      end
      default: begin
        rn = amag;
        rd = admag;
        rneg = aneg;
      end
    endcase
    g = gcd64(rn, rd);
    if (g != 0) begin
      rn = rn / g;
      rd = rd / g;
    end
    if (rn == 0) begin
      rneg = 1'b0;
      rd = 1;
    end
    lim = 64'd1 << ((WIDTH_EFF) - 1);
    if (!(rd >= 1 && rd <= lim - 1 && (rneg ? rn <= lim : rn <= lim - 1))) begin
      r.st = ST_OVF;
      return r;
    end
    r.num = rneg ? -rn[31:0] : rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  task automatic send_item(input op_e op, input logic signed [31:0] an,
                           input logic signed [31:0] ad, input logic signed [31:0] bn,
                           input logic signed [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    expected_q.push_back(rational_result(op, an, ad, bn, bd));
    in_valid_i <= 1'b1;
    req_type_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom_range(9) - 4;
      1: return $urandom_range(200) - 100;
      2: return 32'sh7fffffff - $urandom_range(3);
      3: return 32'sh80000000 + $urandom_range(3);
      4: return $urandom_range(70000) - 35000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_den();
    logic signed [31:0] v;
    v = rand_val();
    if ($urandom_range(9) != 0 && v <= 0) v = (v == 0) ? 1 : -(v + 1);
    if ($urandom_range(30) == 0) v = 0;
    if ($urandom_range(15) == 0) v = -($urandom_range(50) + 1);
    return v;
  endfunction

  task automatic test_directed();
    send_item(OP_NORM, 6, -4, 0, 1);
    send_item(OP_NORM, 0, -7, 0, 1);
    send_item(OP_NORM, 32'sh80000000, 1, 0, 1);
    send_item(OP_NORM, 32'sh80000000, -1, 0, 1);
    send_item(OP_NORM, 32'sh7fffffff, 32'sh80000000, 0, 1);
    send_item(OP_NORM, 5, 0, 1, 1);
    send_item(OP_ADD, 1, 2, 1, 3);
    send_item(OP_ADD, 32'sh7fffffff, 1, 1, 1);
    send_item(OP_ADD, 1, 3, 1, 0);
    send_item(OP_SUB, 1, 2, 1, 2);
    send_item(OP_SUB, 32'sh80000000, 1, 1, 1);
    send_item(OP_MUL, 32'sh7fffffff, 32'sh7ffffffe, 32'sh7ffffffe, 32'sh7fffffff);
    send_item(OP_MUL, 32'sh80000000, 1, -1, 1);
    send_item(OP_DIV, 3, 4, 0, 5);
    send_item(OP_DIV, 3, 4, -9, 8);
    send_item(OP_NEG, 32'sh80000000, 1, 7, 0);
    send_item(OP_NEG, 32'sh7fffffff, -3, 0, 0);
    send_item(OP_CMP, 1, 3, 2, 6);
    send_item(OP_CMP, -1, 3, 1, 3);
    send_item(OP_CMP, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, -1);
    send_item(OP_CMP, 1, 1, 1, 0);
    send_item(OP_NONE, 32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff);
    send_item(OP_NONE, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_items) begin
      send_item(op_e'($urandom_range(7)), rand_val(), rand_den(), rand_val(), rand_den());
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 2000;
    repeat (6) send_item(op_e'($urandom_range(6)), rand_val(), rand_den(), rand_val(),
                         rand_den());
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    frac_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result item with none expected: num %0d den %0d ord %0d st %0d",
                 $time, res_num_o, res_den_o, order_o, status_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (res_num_o !== exp_r.num || res_den_o !== exp_r.den ||
            order_o !== exp_r.ord || status_o !== exp_r.st) begin
          $display("%0t: mismatch expected num %0d den %0d ord %0d st %0d",
                   $time, exp_r.num, exp_r.den, exp_r.ord, exp_r.st);
          $display("%0t:          actual   num %0d den %0d ord %0d st %0d",
                   $time, res_num_o, res_den_o, order_o, status_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    cycle_cnt = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    req_type_i = OP_NORM;
    a_num_i = '0;
    a_den_i = '0;
    b_num_i = '0;
    b_den_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(530, 29, 58);
    test_backpressure();
    test_random(530, 58, 29);
    test_random(530, 0, 0);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/rau_pkg.sv
src/rational_arithmetic_unit.sv
tb/tb_rational_arithmetic_unit.sv
